FILE: src/lpa_pkg.sv
// ----------------------------------------------------------------------------
// lpa_pkg
// Shared types and constants for the lease pool allocator.
// ----------------------------------------------------------------------------
package lpa_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_BASE_ADDRESS = 2'd0;
  localparam logic [1:0] CFG_SUBNET_MASK  = 2'd1;
  localparam logic [1:0] CFG_POOL_SIZE    = 2'd2;

  localparam logic [31:0] BASE_RESET       = 32'h0000_0000;
  localparam logic [31:0] MASK_RESET       = 32'hFFFF_FF00;
  localparam logic [8:0]  POOL_SIZE_RESET  = 9'd0;
  localparam logic [31:0] FIRST_HOST_OFFSET = 32'd51;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } lpa_state_t;

  // One pool entry as held in the RAM
  typedef struct packed {
    logic        busy;
    logic [31:0] expiry;
    logic [47:0] client;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

FILE: src/lpa_ram.sv
// ----------------------------------------------------------------------------
// lpa_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/lease_pool_allocator_core.sv
// ----------------------------------------------------------------------------
// lease_pool_allocator_core
// First-fit address lease pool: scans the pool RAM for a free or expired entry.
// ----------------------------------------------------------------------------
// After reset the block sweeps the pool RAM to zero, one entry per cycle;
// in_stall stays high during that pass while configuration writes are taken
// as usual. One request is handled at a time. The scan reads one pool
// entry per cycle through the RAM's single read port, over at most
// min(pool_size, POOL_DEPTH) entries; with a pool size of zero the
// request goes straight to the result. The next request is accepted as
// soon as the previous result sits in the output register, even while it
// is still stalled.
module lease_pool_allocator_core
  import lpa_pkg::*;
#(
  parameter int POOL_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [47:0] in_client_mac,
  input  logic [31:0] in_lease_seconds,
  input  logic [31:0] in_now_seconds,

  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_granted,
  output logic [31:0] out_leased_address,
  output logic [7:0]  out_entry_index
);

  localparam int AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int CW = $clog2(POOL_DEPTH + 1);
  localparam int LW = (CW > 9) ? CW : 9;

  lpa_state_t state_r, state_nxt;

  logic [31:0]   base_r;
  logic [31:0]   mask_r;
  logic [8:0]    pool_size_r;

  logic [AW-1:0] clr_r;
  logic [CW-1:0] issue_r;
  logic          rd_vld_r;
  logic [AW-1:0] rd_idx_r;
  logic [CW-1:0] lim_r;

  logic [47:0]   mac_r;
  logic [31:0]   exp_r;
  logic [31:0]   now_r;
  logic [31:0]   net51_r;

  logic          res_granted_r;
  logic [31:0]   res_addr_r;
  logic [7:0]    res_index_r;

  logic          out_valid_r;
  logic          out_granted_r;
  logic [31:0]   out_addr_r;
  logic [7:0]    out_index_r;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t        rd_entry;
  entry_t        wr_entry;

  logic          take_req;
  logic          rd_issue;
  logic          hit;
  logic          miss_end;
  logic          out_load;
  logic          qual;
  logic          last_entry;
  logic [CW-1:0] limit;
  logic [32:0]   exp_sum;

  // Pool size clipped to the RAM depth
  always_comb begin
    if (LW'(pool_size_r) > LW'(POOL_DEPTH)) begin
      limit = CW'(POOL_DEPTH);
    end else begin
      limit = CW'(pool_size_r);
    end
  end

  assign exp_sum    = {1'b0, in_now_seconds} + {1'b0, in_lease_seconds};
  assign rd_entry   = entry_t'(ram_rdata);
  assign qual       = !rd_entry.busy || (rd_entry.expiry <= now_r);
  assign last_entry = (CW'(rd_idx_r) + CW'(1)) == lim_r;

  always_comb begin
    wr_entry.busy   = 1'b1;
    wr_entry.expiry = exp_r;
    wr_entry.client = mac_r;
  end

  lpa_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (POOL_DEPTH),
    .AW    (AW)
  ) u_pool_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (issue_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Next state and control
  always_comb begin
    state_nxt = state_r;
    ram_we    = 1'b0;
    ram_waddr = rd_idx_r;
    ram_wdata = '0;
    take_req  = 1'b0;
    rd_issue  = 1'b0;
    hit       = 1'b0;
    miss_end  = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        if (clr_r == AW'(POOL_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          take_req  = 1'b1;
          state_nxt = (limit == '0) ? ST_RESP : ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_issue = issue_r < lim_r;
        if (rd_vld_r) begin
          if (qual) begin
            hit       = 1'b1;
            ram_we    = 1'b1;
            ram_wdata = wr_entry;
            state_nxt = ST_RESP;
          end else if (last_entry) begin
            miss_end  = 1'b1;
            state_nxt = ST_RESP;
          end
        end
      end
      ST_RESP: begin
        out_load = !out_valid_r || !out_stall;
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= BASE_RESET;
      mask_r      <= MASK_RESET;
      pool_size_r <= POOL_SIZE_RESET;
      clr_r       <= '0;
      issue_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_BASE_ADDRESS: base_r      <= cfg_wdata;
          CFG_SUBNET_MASK:  mask_r      <= cfg_wdata;
          CFG_POOL_SIZE:    pool_size_r <= cfg_wdata[8:0];
          default: ;
        endcase
      end
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + AW'(1);
      end
      if (take_req) begin
        issue_r <= '0;
      end else if (rd_issue) begin
        issue_r <= issue_r + CW'(1);
      end
      rd_vld_r <= rd_issue && !hit && !miss_end;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request and result payload
  always_ff @(posedge clk) begin
    if (take_req) begin
      mac_r         <= in_client_mac;
      now_r         <= in_now_seconds;
      exp_r         <= exp_sum[32] ? 32'hFFFF_FFFF : exp_sum[31:0];
      net51_r       <= (base_r & mask_r) + FIRST_HOST_OFFSET;
      lim_r         <= limit;
      res_granted_r <= 1'b0;
      res_addr_r    <= '0;
      res_index_r   <= '0;
    end else if (hit) begin
      res_granted_r <= 1'b1;
      res_addr_r    <= net51_r + 32'(rd_idx_r);
      res_index_r   <= 8'(rd_idx_r);
    end
    if (rd_issue) begin
      rd_idx_r <= issue_r[AW-1:0];
    end
    if (out_load) begin
      out_granted_r <= res_granted_r;
      out_addr_r    <= res_addr_r;
      out_index_r   <= res_index_r;
    end
  end

  assign in_stall           = state_r != ST_IDLE;
  assign out_valid          = out_valid_r;
  assign out_granted        = out_granted_r;
  assign out_leased_address = out_addr_r;
  assign out_entry_index    = out_index_r;

  // The pool RAM is written only by the clearing sweep or a grant
  a_ram_write_src: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_CLEAR || (state_r == ST_SCAN && hit)))
    else $error("pool RAM written outside clear sweep or grant");

  // Entries checked never lie beyond the clipped pool size
  a_check_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && rd_vld_r) |-> (CW'(rd_idx_r) < lim_r))
    else $error("scan checked an entry past the pool limit");

  // A refused request reports zero address and index
  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_granted) |-> (out_leased_address == '0 && out_entry_index == '0))
    else $error("refused request carries nonzero address or index");

  // An accepted request starts a scan or goes straight to the result
  a_req_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_SCAN || state_r == ST_RESP))
    else $error("accepted request did not start");

  // A new result is loaded only when the previous one has been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> ($stable(out_granted) && $stable(out_leased_address)))
    else $error("stalled result overwritten");

endmodule

FILE: bench/lpa_grant_checker.sv
// ----------------------------------------------------------------------------
// lpa_grant_checker
// Watches the config, request and result ports of the lease pool allocator.
// It keeps its own copy of the pool and the registers and predicts each
// grant. Results are checked in order against the predictions.
// ----------------------------------------------------------------------------
module lpa_grant_checker
  import lpa_pkg::*;
#(
  parameter int POOL_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,

  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [47:0] in_client_mac,
  input  logic [31:0] in_lease_seconds,
  input  logic [31:0] in_now_seconds,

  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_granted,
  input  logic [31:0] out_leased_address,
  input  logic [7:0]  out_entry_index,

  output int          error_count,
  output int          outstanding,
  output int          grant_count,
  output int          refuse_count
);

  typedef struct packed {
    logic        granted;
    logic [31:0] address;
    logic [7:0]  index;
  } lease_grant_t;

  logic [31:0] net_base;
  logic [31:0] net_mask;
  logic [8:0]  pool_size;

  logic        slot_busy   [POOL_DEPTH];
  logic [31:0] slot_expiry [POOL_DEPTH];
  logic [47:0] slot_client [POOL_DEPTH];

  lease_grant_t grant_q [$];

  // First-fit scan; claims the chosen slot as a side effect.
  function automatic lease_grant_t allocate_lease(logic [47:0] mac, logic [31:0] lease,
                                                  logic [31:0] now);
    lease_grant_t res;
    logic [32:0]  sum;
    int           limit;
    res = '0;
    sum = {1'b0, now} + {1'b0, lease};
    limit = (pool_size > POOL_DEPTH) ? POOL_DEPTH : int'(pool_size);
    for (int i = 0; i < limit; i++) begin
      if (!slot_busy[i] || slot_expiry[i] <= now) begin
        slot_busy[i]   = 1'b1;
        slot_client[i] = mac;
        slot_expiry[i] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        res.granted = 1'b1;
        res.address = (net_base & net_mask) + FIRST_HOST_OFFSET + 32'(i);
        res.index   = i[7:0];
        return res;
      end
    end
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_val, act_val);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    lease_grant_t exp_grant;
    if (!rst_n) begin
      net_base  = BASE_RESET;
      net_mask  = MASK_RESET;
      pool_size = POOL_SIZE_RESET;
      for (int i = 0; i < POOL_DEPTH; i++) begin
        slot_busy[i]   = 1'b0;
        slot_expiry[i] = '0;
        slot_client[i] = '0;
      end
      grant_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BASE_ADDRESS: net_base  = cfg_wdata;
          CFG_SUBNET_MASK:  net_mask  = cfg_wdata;
          CFG_POOL_SIZE:    pool_size = cfg_wdata[8:0];
          default: ;
        endcase
      end
      // results first: a result leaving this edge belongs to an older request
      if (out_valid && !out_stall) begin
        if (grant_q.size() == 0) begin
          $display("%0t: result with no request pending: granted %0b, address %0h, index %0h",
                   $time, out_granted, out_leased_address, out_entry_index);
          error_count++;
        end else begin
          exp_grant = grant_q.pop_front();
          check_field("granted", 32'(exp_grant.granted), 32'(out_granted));
          check_field("leased_address", exp_grant.address, out_leased_address);
          check_field("entry_index", 32'(exp_grant.index), 32'(out_entry_index));
          if (exp_grant.granted) grant_count++;
          else refuse_count++;
        end
      end
      if (in_valid && !in_stall) begin
        grant_q.push_back(allocate_lease(in_client_mac, in_lease_seconds, in_now_seconds));
      end
    end
    outstanding = grant_q.size();
  end

endmodule

FILE: bench/lease_pool_allocator_core_tb.sv
// ----------------------------------------------------------------------------
// lease_pool_allocator_core_tb
// Drives lease requests and register writes into the allocator core.
// A directed set covers the empty pool, reuse of expired leases, expiry
// saturation, pool exhaustion, address wrap and ignored register writes;
// random phases with varying idle and stall patterns follow, then a fill
// of the whole pool and a short zero-size run; lpa_grant_checker checks.
// ----------------------------------------------------------------------------
module lease_pool_allocator_core_tb;
  import lpa_pkg::*;

  localparam int POOL_DEPTH = 256;
  // sized for the slowest run: ~550 requests x (full scan + long gaps and
  // stalls) plus the clearing pass and the hold-off
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 600;
  localparam int DRAIN_LIMIT = 50_000;
  localparam int TAIL_CYCLES = POOL_DEPTH + 16;
  localparam logic [1:0]  CFG_UNUSED = 2'd3;
  localparam logic [31:0] SEC_MAX = 32'hFFFF_FFFF;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [47:0] in_client_mac;
  logic [31:0] in_lease_seconds;
  logic [31:0] in_now_seconds;
  logic        out_valid;
  logic        out_stall;
  logic        out_granted;
  logic [31:0] out_leased_address;
  logic [7:0]  out_entry_index;

  int          error_count;
  int          outstanding;
  int          grant_count;
  int          refuse_count;

  int          sender_idle_pct;
  int          stall_pct;
  bit          hold_request;
  logic [31:0] wall_clock;

  always #1 clk = ~clk;

  lease_pool_allocator_core #(
    .POOL_DEPTH(POOL_DEPTH)
  ) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_client_mac     (in_client_mac),
    .in_lease_seconds  (in_lease_seconds),
    .in_now_seconds    (in_now_seconds),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_granted       (out_granted),
    .out_leased_address(out_leased_address),
    .out_entry_index   (out_entry_index)
  );

  lpa_grant_checker #(
    .POOL_DEPTH(POOL_DEPTH)
  ) i_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_client_mac     (in_client_mac),
    .in_lease_seconds  (in_lease_seconds),
    .in_now_seconds    (in_now_seconds),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_granted       (out_granted),
    .out_leased_address(out_leased_address),
    .out_entry_index   (out_entry_index),
    .error_count       (error_count),
    .outstanding       (outstanding),
    .grant_count       (grant_count),
    .refuse_count      (refuse_count)
  );

  // Watchdog
  initial begin
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("%0t: timeout after %0d cycles, %0d results pending",
                 $time, cycles, outstanding);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Result side: random stall, plus a long hold-off on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        repeat (HOLD_CYCLES) begin
          out_stall <= 1'b1;
          @(negedge clk);
        end
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  task automatic send_request(input logic [47:0] mac, input logic [31:0] lease,
                              input logic [31:0] now);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_client_mac    <= mac;
    in_lease_seconds <= lease;
    in_now_seconds   <= now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Mostly a steadily advancing clock with short leases so slots expire and
  // get reused; the rest is noise with arbitrary times and lengths.
  task automatic random_request();
    logic [31:0] lease;
    logic [31:0] now;
    if ($urandom_range(0, 99) < 88) begin
      wall_clock = wall_clock + $urandom_range(0, 3);
      now = wall_clock;
      case ($urandom_range(0, 24))
        0:       lease = $urandom;
        1, 2:    lease = '0;
        default: lease = $urandom_range(1, 24);
      endcase
    end else begin
      now   = ($urandom_range(0, 3) == 0) ? SEC_MAX : $urandom;
      lease = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 40);
    end
    send_request({16'($urandom), 32'($urandom)}, lease, now);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(input logic [31:0] base, input logic [31:0] mask,
                           input logic [31:0] pool_word);
    cfg_write(CFG_BASE_ADDRESS, base);
    cfg_write(CFG_SUBNET_MASK, mask);
    cfg_write(CFG_POOL_SIZE, pool_word);
  endtask

  task automatic random_subnet(input logic [31:0] pool_word);
    logic [31:0] mask;
    mask = ($urandom_range(0, 4) == 0) ? $urandom : SEC_MAX << $urandom_range(0, 32);
    configure($urandom, mask, pool_word);
  endtask

  // Block is idle once every request has its result
  task automatic settle();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_phase(input int count, input int idle_pct, input int stall_chance);
    sender_idle_pct = idle_pct;
    stall_pct       = stall_chance;
    repeat (count) random_request();
    settle();
  endtask

  initial begin
    int drain_cycles;
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_BASE_ADDRESS;
    cfg_wdata        <= '0;
    in_valid         <= 1'b0;
    in_client_mac    <= '0;
    in_lease_seconds <= '0;
    in_now_seconds   <= '0;
    sender_idle_pct = 0;
    stall_pct       = 0;
    wall_clock      = 32'd1000;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings leave the pool size at zero: nothing can be granted
    send_request('1, SEC_MAX, SEC_MAX);
    settle();

    configure(32'hC0A8_0164, 32'hFFFF_FF00, 32'd4);
    send_request(48'h0, 32'd10, 32'd0);
    send_request('1, 32'd0, 32'd0);
    // zero-length lease is free again at once
    send_request(48'h0000_5E00_0101, 32'd5, 32'd1);
    send_request(48'h0A0B_0C0D_0E0F, 32'd100, 32'd1);
    // jump in time: all expired; expiry saturates
    send_request(48'h1111_2222_3333, SEC_MAX, 32'hFFFF_FFF0);
    send_request(48'h2, 32'd5, 32'hFFFF_FFF0);
    send_request(48'h3, 32'd3, 32'hFFFF_FFF0);
    send_request(48'h4, SEC_MAX, 32'hFFFF_FFF0);
    // every slot busy and live: refused; the later times reach expired slots again
    send_request(48'h5, 32'd1, 32'hFFFF_FFF0);
    send_request(48'h6, 32'd1, 32'hFFFF_FFF4);
    send_request(48'h7, 32'd0, SEC_MAX);
    settle();

    // network + offset + index wraps past 2^32
    configure(SEC_MAX, SEC_MAX, 32'd4);
    send_request(48'h8, 32'd0, SEC_MAX);
    settle();
    // write to an unmapped index must leave the pool size alone
    cfg_write(CFG_UNUSED, 32'd0);
    send_request(48'h9, 32'd0, SEC_MAX);
    settle();
    // pool size above depth (upper write bits dropped)
    cfg_write(CFG_POOL_SIZE, SEC_MAX);
    send_request(48'hA, 32'd7, 32'd0);
    settle();

    configure(32'h0, 32'hFFFF_0000, 32'd8);
    run_phase(50, 0, 0);
    random_subnet(32'($urandom_range(6, 16)));
    run_phase(50, 83, 0);
    random_subnet(32'($urandom_range(6, 16)));
    run_phase(50, 0, 83);
    random_subnet(32'($urandom_range(6, 16)));
    run_phase(50, 19, 19);

    // long output hold-off while requests keep coming: input must back up
    random_subnet(32'd12);
    hold_request = 1'b1;
    run_phase(24, 0, 0);

    random_subnet(32'd16);
    run_phase(50, 19, 19);

    // fill the whole pool with leases that never expire; the last requests
    // must be refused after a scan limited to the pool depth
    random_subnet(SEC_MAX);
    sender_idle_pct = 19;
    stall_pct       = 19;
    repeat (POOL_DEPTH + 2) begin
      send_request({16'($urandom), 32'($urandom)}, $urandom | 32'h8000_0000,
                   32'h8000_0000 + $urandom_range(0, 1000));
    end
    settle();

    random_subnet(32'd0);
    run_phase(4, 0, 0);

    sender_idle_pct = 0;
    stall_pct       = 0;
    drain_cycles    = 0;
    while (outstanding != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(negedge clk);
      drain_cycles++;
    end
    repeat (TAIL_CYCLES) @(negedge clk);

    if (outstanding != 0) $display("%0t: %0d results never arrived", $time, outstanding);
    $display("Covered %0d lease requests: %0d granted, %0d refused.",
             grant_count + refuse_count, grant_count, refuse_count);
    $display("Phases: back-to-back, sparse requests, heavy stall, mixed idling, long hold-off, full pool.");
    if (error_count == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
